[hdl/bsc_pkg.sv]
// bsc_pkg: shared sizes, codes and word types for the safety check block
// used by bsc_tables and bankers_safety_check; no dependencies
package bsc_pkg;

   localparam int MAX_PROCS     = 16;
   localparam int MAX_RES       = 8;
   localparam int COUNT_BITS    = 16;
   localparam int AVAIL_BITS    = 20;
   localparam int PROC_BITS     = $clog2(MAX_PROCS);
   localparam int RES_BITS      = $clog2(MAX_RES);
   localparam int TBL_ADDR_BITS = PROC_BITS + RES_BITS;
   localparam int TBL_DEPTH     = MAX_PROCS * MAX_RES;
   localparam int PCNT_BITS     = PROC_BITS + 1;
   localparam int RCNT_BITS     = RES_BITS + 1;

   // request function codes
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_MAX   = 2'd1;
   localparam logic [1:0] FUNC_AVAIL = 2'd2;
   localparam logic [1:0] FUNC_CHECK = 2'd3;

   // control register port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROC_COUNT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RES_COUNT  = 4'd1;

   localparam logic [4:0] PROC_COUNT_RESET = 5'd16;
   localparam logic [3:0] RES_COUNT_RESET  = 4'd8;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  proc_index;
      logic [2:0]  res_index;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0] process_id;
      logic       is_safe;
      logic       last;
   } rsp_type;

   // write side of the two demand tables
   typedef struct packed {
      logic                     alloc_en;
      logic                     max_en;
      logic [TBL_ADDR_BITS-1:0] addr;
      logic [COUNT_BITS-1:0]    data;
   } tbl_wr_type;

endpackage

[hdl/bsc_tables.sv]
// bsc_tables: allocation and maximum-demand tables, one write and one
// registered read port each; depends on bsc_pkg
module bsc_tables
   import bsc_pkg::*;
(
   input  logic                     clock,
   input  tbl_wr_type               wr,
   input  logic [TBL_ADDR_BITS-1:0] rd_addr,
   output logic [COUNT_BITS-1:0]    alloc_q,
   output logic [COUNT_BITS-1:0]    max_q
);

   logic [COUNT_BITS-1:0] alloc_mem [TBL_DEPTH];
   logic [COUNT_BITS-1:0] max_mem   [TBL_DEPTH];
   logic [COUNT_BITS-1:0] alloc_q_ff;
   logic [COUNT_BITS-1:0] max_q_ff;

   always_ff @(posedge clock) begin
      if (wr.alloc_en) begin
         alloc_mem[wr.addr] <= wr.data;
      end
      if (wr.max_en) begin
         max_mem[wr.addr] <= wr.data;
      end
      alloc_q_ff <= alloc_mem[rd_addr];
      max_q_ff   <= max_mem[rd_addr];
   end

   assign alloc_q = alloc_q_ff;
   assign max_q   = max_q_ff;

endmodule

[hdl/bankers_safety_check.sv]
// bankers_safety_check: top level, sequencer for the safety test around
// one shared adder/comparator; depends on bsc_pkg and bsc_tables
//
// Usage. A request word is taken when start is high and busy is low.
// Functions allocation and maximum write one table entry, available
// writes one entry of the available vector; busy stays low. A check word
// raises busy while the sequencer walks the tables: each process visit
// reads one resource column at a time through the table read port,
// first comparing max against alloc + avail, then releasing alloc into
// avail through the same 21-bit adder. A finished process is skipped.
// A pass visits proc_count processes (clamped to 1..16) and at most
// proc_count passes run, ending early once all finish or a pass adds
// nobody. Results follow: proc_count words of the safe sequence, one per
// cycle with last on the final one, or a single unsafe word. Each result
// is shown for one cycle with rsp_valid; the receiver cannot stall, so
// nothing is held back. The csr port is always ready; the user must
// write it only while idle, which the block itself does not enforce. Reset
// returns the sequencer to idle and the counts to 16 processes and 8
// resources; table contents are kept undefined until written.
module bankers_safety_check
   import bsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PROC  = 3'd1;
   localparam logic [2:0] S_FIT   = 3'd2;
   localparam logic [2:0] S_FWAIT = 3'd3;
   localparam logic [2:0] S_RWAIT = 3'd4;
   localparam logic [2:0] S_REL   = 3'd5;
   localparam logic [2:0] S_NEXTP = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   localparam logic [AVAIL_BITS-1:0] AVAIL_MAX = {AVAIL_BITS{1'b1}};

   logic [2:0]           state_ff,    state_in;
   logic [4:0]           proc_cnt_ff, proc_cnt_in;
   logic [3:0]           res_cnt_ff,  res_cnt_in;
   logic [PCNT_BITS-1:0] np_ff,       np_in;
   logic [RCNT_BITS-1:0] nr_ff,       nr_in;
   logic [PROC_BITS-1:0] p_ff,        p_in;
   logic [RES_BITS-1:0]  r_ff,        r_in;
   logic [PCNT_BITS-1:0] pass_ff,     pass_in;
   logic [PCNT_BITS-1:0] cnt_ff,      cnt_in;
   logic                 progress_ff, progress_in;
   logic [MAX_PROCS-1:0] finished_ff, finished_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff,      rsp_in;

   logic [AVAIL_BITS-1:0] avail_ff [MAX_RES];
   logic [PROC_BITS-1:0]  seq_ff   [MAX_PROCS];

   tbl_wr_type            tbl_wr;
   logic [COUNT_BITS-1:0] alloc_q;
   logic [COUNT_BITS-1:0] max_q;

   logic                  accept;
   logic [AVAIL_BITS:0]   unit_sum;
   logic                  unit_fits;
   logic                  last_res;
   logic                  last_proc;
   logic                  avail_wr;
   logic                  seq_wr;
   logic [PCNT_BITS-1:0]  np_clamp;
   logic [RCNT_BITS-1:0]  nr_clamp;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tbl_wr.alloc_en = accept && (req_data.func == FUNC_ALLOC);
   assign tbl_wr.max_en   = accept && (req_data.func == FUNC_MAX);
   assign tbl_wr.addr     = {req_data.proc_index[PROC_BITS-1:0],
                             req_data.res_index[RES_BITS-1:0]};
   assign tbl_wr.data     = req_data.value[COUNT_BITS-1:0];

   bsc_tables u_tables (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr ({p_ff, r_ff}),
      .alloc_q (alloc_q),
      .max_q   (max_q)
   );

   // shared unit: need fits when max <= alloc + avail; the same sum is the release
   assign unit_sum  = {1'b0, avail_ff[r_ff]} +
                      {{(AVAIL_BITS + 1 - COUNT_BITS){1'b0}}, alloc_q};
   assign unit_fits = {{(AVAIL_BITS + 1 - COUNT_BITS){1'b0}}, max_q} <= unit_sum;

   assign last_res  = ({1'b0, r_ff} == nr_ff - 1'b1);
   assign last_proc = ({1'b0, p_ff} == np_ff - 1'b1);

   always_comb begin
      if (proc_cnt_ff == 5'd0) begin
         np_clamp = PCNT_BITS'(1);
      end else if (proc_cnt_ff > 5'(MAX_PROCS)) begin
         np_clamp = PCNT_BITS'(MAX_PROCS);
      end else begin
         np_clamp = PCNT_BITS'(proc_cnt_ff);
      end
      if (res_cnt_ff == 4'd0) begin
         nr_clamp = RCNT_BITS'(1);
      end else if (res_cnt_ff > 4'(MAX_RES)) begin
         nr_clamp = RCNT_BITS'(MAX_RES);
      end else begin
         nr_clamp = RCNT_BITS'(res_cnt_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      proc_cnt_in  = proc_cnt_ff;
      res_cnt_in   = res_cnt_ff;
      np_in        = np_ff;
      nr_in        = nr_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      progress_in  = progress_ff;
      finished_in  = finished_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      avail_wr     = 1'b0;
      seq_wr       = 1'b0;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PROC_COUNT) begin
            proc_cnt_in = csr_data[4:0];
         end else if (csr_index == CSR_RES_COUNT) begin
            res_cnt_in = csr_data[3:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.func == FUNC_CHECK) begin
               np_in       = np_clamp;
               nr_in       = nr_clamp;
               p_in        = '0;
               r_in        = '0;
               pass_in     = '0;
               cnt_in      = '0;
               progress_in = 1'b0;
               finished_in = '0;
               state_in    = S_PROC;
            end
         end
         S_PROC: begin
            // read of column 0 is under way
            state_in = finished_ff[p_ff] ? S_NEXTP : S_FIT;
         end
         S_FIT: begin
            if (!unit_fits) begin
               state_in = S_NEXTP;
            end else if (last_res) begin
               r_in     = '0;
               state_in = S_RWAIT;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: begin
            state_in = S_FIT;
         end
         S_RWAIT: begin
            state_in = S_REL;
         end
         S_REL: begin
            avail_wr = 1'b1;
            if (last_res) begin
               seq_wr               = 1'b1;
               cnt_in               = cnt_ff + 1'b1;
               finished_in[p_ff]    = 1'b1;
               progress_in          = 1'b1;
               state_in             = S_NEXTP;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = S_RWAIT;
            end
         end
         S_NEXTP: begin
            r_in = '0;
            if (last_proc) begin
               p_in = '0;
               // no progress in a pass means later passes change nothing
               if (cnt_ff == np_ff || !progress_ff || pass_ff == np_ff - 1'b1) begin
                  state_in = S_EMIT;
               end else begin
                  pass_in     = pass_ff + 1'b1;
                  progress_in = 1'b0;
                  state_in    = S_PROC;
               end
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = S_PROC;
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            if (cnt_ff != np_ff) begin
               rsp_in.process_id = '0;
               rsp_in.is_safe    = 1'b0;
               rsp_in.last       = 1'b1;
               state_in          = S_IDLE;
            end else begin
               rsp_in.process_id = 4'(seq_ff[p_ff]);
               rsp_in.is_safe    = 1'b1;
               rsp_in.last       = last_proc;
               p_in              = p_ff + 1'b1;
               if (last_proc) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         proc_cnt_ff  <= PROC_COUNT_RESET;
         res_cnt_ff   <= RES_COUNT_RESET;
         finished_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         proc_cnt_ff  <= proc_cnt_in;
         res_cnt_ff   <= res_cnt_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff       <= np_in;
      nr_ff       <= nr_in;
      p_ff        <= p_in;
      r_ff        <= r_in;
      pass_ff     <= pass_in;
      cnt_ff      <= cnt_in;
      progress_ff <= progress_in;
      rsp_ff      <= rsp_in;
   end

   // available vector: load words and saturating releases
   always_ff @(posedge clock) begin
      if (accept && req_data.func == FUNC_AVAIL) begin
         avail_ff[req_data.res_index[RES_BITS-1:0]] <=
            {{(AVAIL_BITS - COUNT_BITS){1'b0}}, req_data.value[COUNT_BITS-1:0]};
      end else if (avail_wr) begin
         avail_ff[r_ff] <= unit_sum[AVAIL_BITS] ? AVAIL_MAX : unit_sum[AVAIL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (seq_wr) begin
         seq_ff[cnt_ff[PROC_BITS-1:0]] <= p_ff;
      end
   end

endmodule
